>>> sv/lsrc_pkg.sv
// Shared constants and types of the line segment rectangle clipper.
`timescale 1ns / 1ps

package lsrc_pkg;

  // Width of one coordinate field on the ports.
  localparam int COORD_BITS = 16;
  // Width of the window registers.
  localparam int WIN_BITS = 12;
  // Internal coordinate width: must hold both a port coordinate and a window edge.
  localparam int SPAN_W = (COORD_BITS > WIN_BITS + 1) ? COORD_BITS : WIN_BITS + 1;
  // Signed width of a difference of two internal coordinates.
  localparam int CALC_W = SPAN_W + 1;
  // Width of the magnitude of such a difference.
  localparam int MAG_W = SPAN_W;
  // Divider stages, two quotient bits per stage.
  localparam int DIV_STAGES = (MAG_W + 1) / 2;

  // Stream widths.
  localparam int IN_DATA_W = ((4 * COORD_BITS + 8 + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((4 * COORD_BITS + 8 + 7) / 8) * 8;
  localparam int OUT_USER_W = 3;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = 2'd3;

  // Window after reset.
  localparam logic [WIN_BITS-1:0] RST_LEFT = 12'd0;
  localparam logic [WIN_BITS-1:0] RST_RIGHT = 12'd319;
  localparam logic [WIN_BITS-1:0] RST_TOP = 12'd0;
  localparam logic [WIN_BITS-1:0] RST_BOTTOM = 12'd199;

  // Segment kinds.
  localparam logic [1:0] KIND_HORIZ = 2'd0;
  localparam logic [1:0] KIND_VERT = 2'd1;
  localparam logic [1:0] KIND_GENERAL = 2'd2;

  // One segment as it travels down the pipeline.
  typedef struct packed {
    logic signed [SPAN_W-1:0] x1;
    logic signed [SPAN_W-1:0] y1;
    logic signed [SPAN_W-1:0] x2;
    logic signed [SPAN_W-1:0] y2;
    logic [7:0]               colour;
    logic [1:0]               kind;
    logic                     rej;
    logic                     fwd_x;
    logic                     fwd_y;
  } item_t;

  // Which clip a step performs.
  typedef struct packed {
    logic axis_y;
    logic second;
  } step_sel_t;

endpackage

>>> sv/line_segment_rect_clipper.sv
// Top level of the line segment clipper: window registers, classification and output stage.
// Stages from an accepted request to its result, the four chained dividers setting the depth:
//   one classify stage, four clip steps of (3 + DIV_STAGES) stages each, one output stage.
// Throughput: one segment per cycle unless stalled; dividers give two quotient bits per stage.
// A result held on the output stalls the whole pipeline until it is taken.
// Reset clears all valid bits and sets the window to columns 0..319, rows 0..199.
`timescale 1ns / 1ps

module line_segment_rect_clipper (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lsrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsrc_pkg::WIN_BITS-1:0]      cfg_data,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // start_x, start_y, end_x, end_y, colour
  input  logic [lsrc_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // out_x_a, out_y_a, out_x_b, out_y_b, out_colour
  output logic [lsrc_pkg::OUT_DATA_W-1:0]    m_tdata,
  // visible, segment_kind
  output logic [lsrc_pkg::OUT_USER_W-1:0]    m_tuser
);

  localparam int CB = lsrc_pkg::COORD_BITS;

  // Window registers.
  logic [lsrc_pkg::WIN_BITS-1:0] win_left;
  logic [lsrc_pkg::WIN_BITS-1:0] win_right;
  logic [lsrc_pkg::WIN_BITS-1:0] win_top;
  logic [lsrc_pkg::WIN_BITS-1:0] win_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_left <= lsrc_pkg::RST_LEFT;
      win_right <= lsrc_pkg::RST_RIGHT;
      win_top <= lsrc_pkg::RST_TOP;
      win_bottom <= lsrc_pkg::RST_BOTTOM;
    end else if (cfg_we) begin
      case (cfg_index)
        lsrc_pkg::REG_LEFT:   win_left <= cfg_data;
        lsrc_pkg::REG_RIGHT:  win_right <= cfg_data;
        lsrc_pkg::REG_TOP:    win_top <= cfg_data;
        lsrc_pkg::REG_BOTTOM: win_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together whenever the output can move.
  logic en;
  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  // Classify: horizontal, vertical or general, and the x direction.
  logic signed [CB-1:0] in_x1;
  logic signed [CB-1:0] in_y1;
  logic signed [CB-1:0] in_x2;
  logic signed [CB-1:0] in_y2;
  lsrc_pkg::item_t      cls_next;
  lsrc_pkg::item_t      stage_item [0:4];
  logic                 stage_vld [0:4];

  always_comb begin
    in_x1 = s_tdata[CB-1:0];
    in_y1 = s_tdata[2*CB-1:CB];
    in_x2 = s_tdata[3*CB-1:2*CB];
    in_y2 = s_tdata[4*CB-1:3*CB];
    cls_next.x1 = lsrc_pkg::SPAN_W'(in_x1);
    cls_next.y1 = lsrc_pkg::SPAN_W'(in_y1);
    cls_next.x2 = lsrc_pkg::SPAN_W'(in_x2);
    cls_next.y2 = lsrc_pkg::SPAN_W'(in_y2);
    cls_next.colour = s_tdata[4*CB+7:4*CB];
    if (in_y1 == in_y2) begin
      cls_next.kind = lsrc_pkg::KIND_HORIZ;
    end else if (in_x1 == in_x2) begin
      cls_next.kind = lsrc_pkg::KIND_VERT;
    end else begin
      cls_next.kind = lsrc_pkg::KIND_GENERAL;
    end
    cls_next.rej = 1'b0;
    cls_next.fwd_x = (in_x2 >= in_x1);
    cls_next.fwd_y = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld[0] <= 1'b0;
    end else if (en) begin
      stage_vld[0] <= s_tvalid;
    end
    if (en) begin
      stage_item[0] <= cls_next;
    end
  end

  // Four clip steps: x first endpoint, x second, y first, y second.
  for (genvar k = 0; k < 4; k++) begin : g_step
    lsrc_pkg::step_sel_t sel;
    assign sel.axis_y = (k >= 2);
    assign sel.second = (k % 2 == 1);

    lsrc_clip_step u_step (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .sel      (sel),
      .bound_lo ((k >= 2) ? win_top : win_left),
      .bound_hi ((k >= 2) ? win_bottom : win_right),
      .in_vld   (stage_vld[k]),
      .in_item  (stage_item[k]),
      .out_vld  (stage_vld[k+1]),
      .out_item (stage_item[k+1])
    );
  end

  // Output: left endpoint first for general segments, zero coordinates for rejected ones.
  lsrc_pkg::item_t      fin;
  logic                 visible;
  logic signed [CB-1:0] xa;
  logic signed [CB-1:0] ya;
  logic signed [CB-1:0] xb;
  logic signed [CB-1:0] yb;

  always_comb begin
    fin = stage_item[4];
    visible = !fin.rej;
    if (fin.rej) begin
      xa = '0; ya = '0; xb = '0; yb = '0;
    end else if (fin.kind == lsrc_pkg::KIND_GENERAL && !fin.fwd_x) begin
      xa = fin.x2[CB-1:0]; ya = fin.y2[CB-1:0];
      xb = fin.x1[CB-1:0]; yb = fin.y1[CB-1:0];
    end else begin
      xa = fin.x1[CB-1:0]; ya = fin.y1[CB-1:0];
      xb = fin.x2[CB-1:0]; yb = fin.y2[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= stage_vld[4];
    end
    if (en) begin
      m_tdata <= lsrc_pkg::OUT_DATA_W'({fin.colour, yb, xb, ya, xa});
      m_tuser <= {fin.kind, visible};
    end
  end

  // A rejected segment is always a general one with all coordinates cleared.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |->
      m_tuser[2:1] == lsrc_pkg::KIND_GENERAL && m_tdata[4*CB-1:0] == '0)
    else $error("rejected result not cleared");

  // Horizontal and vertical segments are never rejected.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2:1] != lsrc_pkg::KIND_GENERAL |-> m_tuser[0])
    else $error("unclipped segment marked invisible");

  // A visible general segment comes out left endpoint first.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] && m_tuser[2:1] == lsrc_pkg::KIND_GENERAL |->
      $signed(m_tdata[CB-1:0]) <= $signed(m_tdata[3*CB-1:2*CB]))
    else $error("general segment not ordered left to right");

endmodule

>>> sv/lsrc_clip_step.sv
// One clip of one endpoint against one window edge, pipelined with a multiplier and divider.
`timescale 1ns / 1ps

module lsrc_clip_step (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  lsrc_pkg::step_sel_t                 sel,
  input  logic [lsrc_pkg::WIN_BITS-1:0]       bound_lo,
  input  logic [lsrc_pkg::WIN_BITS-1:0]       bound_hi,
  input  logic                                in_vld,
  input  lsrc_pkg::item_t                     in_item,
  output logic                                out_vld,
  output lsrc_pkg::item_t                     out_item
);

  typedef struct packed {
    logic                              vld;
    lsrc_pkg::item_t                   item;
    logic                              clip;
    logic [lsrc_pkg::WIN_BITS-1:0]     bnd;
    logic [lsrc_pkg::MAG_W-1:0]        b;
    logic [lsrc_pkg::MAG_W-1:0]        c;
    logic [lsrc_pkg::MAG_W-1:0]        dvmag;
    logic                              neg;
  } set_t;

  typedef struct packed {
    logic                              vld;
    lsrc_pkg::item_t                   item;
    logic                              clip;
    logic [lsrc_pkg::WIN_BITS-1:0]     bnd;
    logic [lsrc_pkg::MAG_W-1:0]        c;
    logic                              neg;
    logic [lsrc_pkg::MAG_W-1:0]        rem;
    logic [lsrc_pkg::MAG_W-1:0]        low;
    logic [lsrc_pkg::MAG_W-1:0]        q;
  } div_t;

  // Two restoring division steps; bits past the quotient width are skipped.
  function automatic div_t div_pair(input div_t d, input int first_bit);
    div_t                       r;
    logic [lsrc_pkg::MAG_W:0]   t;
    r = d;
    for (int j = 0; j < 2; j++) begin
      if (first_bit + j < lsrc_pkg::MAG_W) begin
        t = {r.rem, r.low[lsrc_pkg::MAG_W-1]};
        r.low = {r.low[lsrc_pkg::MAG_W-2:0], 1'b0};
        if (t >= {1'b0, r.c}) begin
          r.rem = lsrc_pkg::MAG_W'(t - {1'b0, r.c});
          r.q = {r.q[lsrc_pkg::MAG_W-2:0], 1'b1};
        end else begin
          r.rem = t[lsrc_pkg::MAG_W-1:0];
          r.q = {r.q[lsrc_pkg::MAG_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  // Setup: pick the moving endpoint, test it against the edge, form the operands.
  logic                                  fwd;
  logic                                  hi_side;
  logic                                  active;
  logic                                  p_out;
  logic                                  o_out;
  logic [lsrc_pkg::WIN_BITS-1:0]         bnd;
  logic signed [lsrc_pkg::SPAN_W-1:0]    pu;
  logic signed [lsrc_pkg::SPAN_W-1:0]    pv;
  logic signed [lsrc_pkg::SPAN_W-1:0]    ou;
  logic signed [lsrc_pkg::SPAN_W-1:0]    ov;
  logic signed [lsrc_pkg::CALC_W-1:0]    bnd_s;
  logic signed [lsrc_pkg::CALC_W-1:0]    db;
  logic signed [lsrc_pkg::CALC_W-1:0]    dc;
  logic signed [lsrc_pkg::CALC_W-1:0]    dv;
  logic signed [lsrc_pkg::CALC_W-1:0]    dc_abs;
  logic signed [lsrc_pkg::CALC_W-1:0]    dv_abs;
  set_t                                  set_next;
  set_t                                  set_r;

  always_comb begin
    if (sel.axis_y && !sel.second) begin
      fwd = (in_item.y2 >= in_item.y1);
    end else if (sel.axis_y) begin
      fwd = in_item.fwd_y;
    end else begin
      fwd = in_item.fwd_x;
    end
    case ({sel.axis_y, sel.second})
      2'b00: begin
        pu = in_item.x1; pv = in_item.y1; ou = in_item.x2; ov = in_item.y2;
      end
      2'b01: begin
        pu = in_item.x2; pv = in_item.y2; ou = in_item.x1; ov = in_item.y1;
      end
      2'b10: begin
        pu = in_item.y1; pv = in_item.x1; ou = in_item.y2; ov = in_item.x2;
      end
      default: begin
        pu = in_item.y2; pv = in_item.x2; ou = in_item.y1; ov = in_item.x1;
      end
    endcase
    hi_side = (fwd == sel.second);
    bnd = hi_side ? bound_hi : bound_lo;
    bnd_s = $signed(lsrc_pkg::CALC_W'(bnd));
    p_out = hi_side ? (lsrc_pkg::CALC_W'(pu) > bnd_s) : (lsrc_pkg::CALC_W'(pu) < bnd_s);
    o_out = hi_side ? (lsrc_pkg::CALC_W'(ou) > bnd_s) : (lsrc_pkg::CALC_W'(ou) < bnd_s);
    active = (in_item.kind == lsrc_pkg::KIND_GENERAL) && !in_item.rej;
    db = hi_side ? (lsrc_pkg::CALC_W'(pu) - bnd_s) : (bnd_s - lsrc_pkg::CALC_W'(pu));
    dc = lsrc_pkg::CALC_W'(ou) - lsrc_pkg::CALC_W'(pu);
    dv = lsrc_pkg::CALC_W'(ov) - lsrc_pkg::CALC_W'(pv);
    dc_abs = dc[lsrc_pkg::CALC_W-1] ? -dc : dc;
    dv_abs = dv[lsrc_pkg::CALC_W-1] ? -dv : dv;

    set_next.vld = in_vld;
    set_next.item = in_item;
    if (sel.axis_y && !sel.second) begin
      set_next.item.fwd_y = fwd;
    end
    set_next.item.rej = in_item.rej || (active && p_out && o_out);
    set_next.clip = active && p_out && !o_out;
    set_next.bnd = bnd;
    set_next.b = db[lsrc_pkg::MAG_W-1:0];
    set_next.c = dc_abs[lsrc_pkg::MAG_W-1:0];
    set_next.dvmag = dv_abs[lsrc_pkg::MAG_W-1:0];
    set_next.neg = dv[lsrc_pkg::CALC_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_r <= '0;
    end else if (en) begin
      set_r <= set_next;
    end
  end

  // Multiply: the numerator magnitude, split into the divider's starting halves.
  // Divider stages follow. The quotient never exceeds the moved coordinate's span,
  // so the upper half of the product is already below the divisor.
  logic [2*lsrc_pkg::MAG_W-1:0] prod;
  div_t                         div_r [0:lsrc_pkg::DIV_STAGES];

  assign prod = set_r.dvmag * set_r.b;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= lsrc_pkg::DIV_STAGES; k++) begin
        div_r[k] <= '0;
      end
    end else if (en) begin
      div_r[0].vld <= set_r.vld;
      div_r[0].item <= set_r.item;
      div_r[0].clip <= set_r.clip;
      div_r[0].bnd <= set_r.bnd;
      div_r[0].c <= set_r.c;
      div_r[0].neg <= set_r.neg;
      div_r[0].rem <= prod[2*lsrc_pkg::MAG_W-1:lsrc_pkg::MAG_W];
      div_r[0].low <= prod[lsrc_pkg::MAG_W-1:0];
      div_r[0].q <= '0;
      for (int k = 0; k < lsrc_pkg::DIV_STAGES; k++) begin
        div_r[k+1] <= div_pair(div_r[k], 2 * k);
      end
    end
  end

  // Update: move the endpoint onto the edge and apply the signed quotient.
  div_t                                  dfin;
  logic signed [lsrc_pkg::CALC_W-1:0]    qs;
  logic signed [lsrc_pkg::CALC_W-1:0]    vsum;
  logic signed [lsrc_pkg::SPAN_W-1:0]    fv;
  logic signed [lsrc_pkg::SPAN_W-1:0]    new_u;
  lsrc_pkg::item_t                       upd_item;

  always_comb begin
    dfin = div_r[lsrc_pkg::DIV_STAGES];
    qs = dfin.neg ? -$signed(lsrc_pkg::CALC_W'(dfin.q)) : $signed(lsrc_pkg::CALC_W'(dfin.q));
    case ({sel.axis_y, sel.second})
      2'b00:   fv = dfin.item.y1;
      2'b01:   fv = dfin.item.y2;
      2'b10:   fv = dfin.item.x1;
      default: fv = dfin.item.x2;
    endcase
    vsum = lsrc_pkg::CALC_W'(fv) + qs;
    new_u = $signed(lsrc_pkg::SPAN_W'(dfin.bnd));
    upd_item = dfin.item;
    if (dfin.clip) begin
      case ({sel.axis_y, sel.second})
        2'b00: begin
          upd_item.x1 = new_u; upd_item.y1 = vsum[lsrc_pkg::SPAN_W-1:0];
        end
        2'b01: begin
          upd_item.x2 = new_u; upd_item.y2 = vsum[lsrc_pkg::SPAN_W-1:0];
        end
        2'b10: begin
          upd_item.y1 = new_u; upd_item.x1 = vsum[lsrc_pkg::SPAN_W-1:0];
        end
        default: begin
          upd_item.y2 = new_u; upd_item.x2 = vsum[lsrc_pkg::SPAN_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= dfin.vld;
    end
    if (en) begin
      out_item <= upd_item;
    end
  end

endmodule
